// ===== design/fsub_pkg.sv =====
// shared types and constants for the truncating single-precision subtractor
package fsub_pkg;

  localparam int unsigned ExpW  = 8;
  localparam int unsigned FracW = 23;
  localparam int unsigned ManW  = FracW + 1;
  localparam int unsigned LzW   = 5;

  localparam logic [ExpW-1:0] ExpMax = 8'hFF;

  // operands after unpack and alignment
  typedef struct packed {
    logic            special;
    logic [31:0]     special_val;
    logic            sa;
    logic            sb;
    logic [ExpW-1:0] e;
    logic [ManW-1:0] ma;
    logic [ManW-1:0] mb;
  } align_t;

  // raw sum or difference before normalisation
  typedef struct packed {
    logic            special;
    logic [31:0]     special_val;
    logic            s;
    logic [ExpW-1:0] e;
    logic [ManW:0]   m;
    logic            add;
  } arith_t;

  function automatic logic [31:0] pack(input logic s, input logic [ExpW-1:0] e,
                                       input logic [ManW-1:0] m);
    pack = {s, e, m[FracW-1:0]};
  endfunction

endpackage

// ===== design/fsub_align.sv =====
// stage 1: unpack, zero detect and exponent alignment
module fsub_align import fsub_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic [31:0] a,
  input  logic [31:0] b,
  output logic        out_valid,
  output align_t      out
);

  align_t r_next;
  logic [ExpW-1:0] ea, eb, diff;
  logic [ManW-1:0] ma, mb;

  always_comb begin
    ea = a[30:23];
    eb = b[30:23];
    ma = {1'b1, a[FracW-1:0]};
    mb = {1'b1, b[FracW-1:0]};
    r_next.sa = a[31];
    r_next.sb = b[31];
    r_next.special = 1'b0;
    r_next.special_val = a;
    if (a[30:0] == 31'd0) begin
      r_next.special = 1'b1;
      r_next.special_val = {~b[31], b[30:0]};
    end else if (b[30:0] == 31'd0) begin
      r_next.special = 1'b1;
    end
    if (ea < eb) begin
      diff = eb - ea;
      r_next.e = eb;
      r_next.ma = (diff >= ExpW'(ManW)) ? '0 : (ma >> diff);
      r_next.mb = mb;
    end else begin
      diff = ea - eb;
      r_next.e = ea;
      r_next.ma = ma;
      r_next.mb = (diff >= ExpW'(ManW)) ? '0 : (mb >> diff);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= in_valid;
    end
    out <= r_next;
  end

endmodule

// ===== design/fsub_addsub.sv =====
// stage 2: mantissa add or magnitude subtract
module fsub_addsub import fsub_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   in_valid,
  input  align_t in,
  output logic   out_valid,
  output arith_t out
);

  arith_t r_next;

  always_comb begin
    r_next.special = in.special;
    r_next.special_val = in.special_val;
    r_next.e = in.e;
    r_next.add = in.sa != in.sb;
    if (in.sa != in.sb) begin
      r_next.m = {1'b0, in.ma} + {1'b0, in.mb};
      r_next.s = in.sa;
    end else if (in.ma > in.mb) begin
      r_next.m = {1'b0, in.ma - in.mb};
      r_next.s = in.sa;
    end else begin
      r_next.m = {1'b0, in.mb - in.ma};
      r_next.s = ~in.sb;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= in_valid;
    end
    out <= r_next;
  end

endmodule

// ===== design/fsub_norm.sv =====
// stage 3 and 4: leading-zero count, then normalise and pack
module fsub_norm import fsub_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  arith_t      in,
  output logic        out_valid,
  output logic [31:0] result
);

  arith_t          r3;
  logic            v3;
  logic [LzW-1:0]  lz, lz_r;
  logic [31:0]     res_next;
  logic [ExpW:0]   einc;
  logic [ExpW-1:0] sh;
  logic [ManW-1:0] mn;

  // leading zeros of the 24-bit mantissa, 24 when zero
  always_comb begin
    lz = LzW'(ManW);
    for (int i = 0; i < ManW; i++) begin
      if (in.m[i]) lz = LzW'(ManW - 1 - i);
    end
  end

  always_comb begin
    einc = {1'b0, r3.e} + 1'b1;
    sh = ({3'b0, lz_r} < r3.e) ? {3'b0, lz_r} : r3.e;
    mn = r3.m[ManW-1:0] << sh;
    if (r3.special) begin
      res_next = r3.special_val;
    end else if (r3.add) begin
      if (r3.m[ManW]) begin
        if (einc >= {1'b0, ExpMax}) res_next = pack(r3.s, ExpMax, '0);
        else res_next = pack(r3.s, einc[ExpW-1:0], r3.m[ManW:1]);
      end else begin
        res_next = pack(r3.s, r3.e, r3.m[ManW-1:0]);
      end
    end else if (r3.m == '0) begin
      res_next = '0;
    end else begin
      res_next = pack(r3.s, r3.e - sh, mn);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      v3 <= in_valid;
      out_valid <= v3;
    end
    r3 <= in;
    lz_r <= lz;
    result <= res_next;
  end

endmodule

// ===== design/float32_subtract_truncating.sv =====
// top level of the truncating single-precision subtractor
//  channel | signals                      | handshake
//  input   | start, minuend, subtrahend   | taken when start and not busy
//  result  | done, difference             | one-cycle strobe, no back-pressure
// four register stages: align, add/subtract, leading-zero count, normalise
// one operand pair per cycle; each result passes through the stages above in order
// busy is always low since the receiver cannot stall
// synchronous reset clears the valid bits only
module float32_subtract_truncating import fsub_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [31:0] minuend,
  input  logic [31:0] subtrahend,
  output logic        done,
  output logic [31:0] difference
);

  logic   v1, v2;
  align_t s1;
  arith_t s2;

  assign busy = 1'b0;

  fsub_align u_align (.clk(clk), .rst(rst), .in_valid(start & ~busy), .a(minuend),
    .b(subtrahend), .out_valid(v1), .out(s1));
  fsub_addsub u_addsub (.clk(clk), .rst(rst), .in_valid(v1), .in(s1),
    .out_valid(v2), .out(s2));
  fsub_norm u_norm (.clk(clk), .rst(rst), .in_valid(v2), .in(s2),
    .out_valid(done), .result(difference));

endmodule

// ===== design/fsub_checker.sv =====
// port-level checks for the subtractor, bound to the top level
module fsub_checker (
  input logic        clk,
  input logic        rst,
  input logic        start,
  input logic        busy,
  input logic        done,
  input logic [31:0] minuend,
  input logic [31:0] subtrahend,
  input logic [31:0] difference
);

  a_latency: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##4 done) else $error("result missing");
  a_no_extra: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, 4)) else $error("spurious result");
  a_zero_b: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && subtrahend[30:0] == 31'd0 && minuend[30:0] != 31'd0)
    |-> ##4 (difference == $past(minuend, 4))) else $error("zero subtrahend");
  a_cancel: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && minuend == subtrahend && minuend[30:0] != 31'd0)
    |-> ##4 (difference == 32'd0)) else $error("cancellation not +0");

endmodule

bind float32_subtract_truncating fsub_checker u_fsub_checker (.*);
